@@ rtl/gaze_dwell_button_qualifier_top_assert.svh @@
// assertion macros for the gaze dwell button qualifier
// used by gaze_dwell_button_qualifier_top, no other dependencies
`ifndef GAZE_DWELL_BUTTON_QUALIFIER_TOP_ASSERT_SVH
`define GAZE_DWELL_BUTTON_QUALIFIER_TOP_ASSERT_SVH

// same-cycle implication under the async low reset
`define GDBQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdbq assertion failed");

// next-cycle implication under the async low reset
`define GDBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdbq assertion failed");

`endif

@@ rtl/gdbq_pkg.sv @@
// types and constants for the gaze dwell button qualifier
// no dependencies
package gdbq_pkg;

  typedef enum logic [1:0] {
    MODE_TAP    = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_ACCEL  = 2'd2,
    MODE_DOUBLE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_RECT_LEFT   = 3'd0,
    CFG_RECT_TOP    = 3'd1,
    CFG_RECT_WIDTH  = 3'd2,
    CFG_RECT_HEIGHT = 3'd3,
    CFG_DWELL_DELAY = 3'd4,
    CFG_BUTTON_MODE = 3'd5,
    CFG_TOGGLE_EN   = 3'd6,
    CFG_AWAY_DECAY  = 3'd7
  } cfg_idx_e;

  typedef logic [1:0] phase_t;

  localparam phase_t PH_IDLE    = 2'd0;
  localparam phase_t PH_DWELL   = 2'd1;
  localparam phase_t PH_ACTIVE  = 2'd2;
  localparam phase_t PH_RELEASE = 2'd3;

  localparam logic signed [3:0] FLASH_LOAD  = 4'sd5;
  localparam logic signed [3:0] FLASH_OFF   = -4'sd1;
  localparam logic signed [4:0] DOUBLE_LOAD = 5'sd12;
  localparam logic signed [4:0] DOUBLE_OFF  = -5'sd1;
  localparam logic [3:0]        REARM_LOAD  = 4'd10;
  localparam logic [15:0]       DELAY_STEP  = 16'd10;
  localparam logic [15:0]       DELAY_FLOOR = 16'd10;

  localparam logic [11:0] RST_RECT_SIZE = 12'd100;
  localparam logic [15:0] RST_DELAY     = 16'd500;

endpackage

@@ rtl/gaze_dwell_button_qualifier_top.sv @@
// channel   | valid      | stall       | payload
// ----------+------------+-------------+--------------------------------------------
// sample in | in_valid_i | in_stall_o  | gaze_x_i, gaze_y_i, now_time_i
// result    | out_valid_o| out_stall_i | fire_count_o, redraw_o, phase_o, flashing_o
// config    | cfg_we_i   | (none)      | cfg_index_i, cfg_wdata_i
//
// one sample per cycle when not stalled; path: sample register, then result register
// the button state is updated when a registered sample moves into the result register
// in_stall_o rises only when both the sample and result registers are full and the
// result is stalled; rst_ni clears control state and loads register defaults
`include "gaze_dwell_button_qualifier_top_assert.svh"

module gaze_dwell_button_qualifier_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  gdbq_pkg::cfg_idx_e cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [13:0] gaze_x_i,
  input  logic signed [13:0] gaze_y_i,
  input  logic [30:0]        now_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         fire_count_o,
  output logic               redraw_o,
  output logic [1:0]         phase_o,
  output logic               flashing_o
);
  import gdbq_pkg::*;

  // configuration
  logic [11:0] left_q, top_q, width_q, height_q;
  logic [15:0] delay_q, decay_q;
  mode_e       mode_q;
  logic        toggle_q;

  // button state
  phase_t             phase_q, phase_d;
  logic [31:0]        dwell_dl_q, dwell_dl_d;
  logic [15:0]        cur_delay_q, cur_delay_d;
  logic signed [3:0]  flash_q, flash_d;
  logic signed [4:0]  double_q, double_d;
  logic [3:0]         rearm_q, rearm_d;
  logic [31:0]        repeat_dl_q, repeat_dl_d;

  // sample register
  logic               s1_valid_q;
  logic signed [13:0] s1_x_q, s1_y_q;
  logic [30:0]        s1_now_q;

  // result register
  logic        out_valid_q;
  logic [1:0]  fire_q, fire_d;
  logic        redraw_q, redraw_d;
  logic [1:0]  phase_out_q;
  logic        flashing_q, flashing_d;

  logic in_accept, s1_adv, out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // inside test, strict on all edges; 15-bit signed avoids overflow of edge sums
  logic signed [14:0] gx, gy, lo_x, hi_x, lo_y, hi_y;
  logic               in_rect;
  logic [31:0]        now32, now_plus;

  assign gx      = 15'(s1_x_q);
  assign gy      = 15'(s1_y_q);
  assign lo_x    = $signed({3'b000, left_q});
  assign hi_x    = $signed({3'b000, left_q} + {3'b000, width_q});
  assign lo_y    = $signed({3'b000, top_q});
  assign hi_y    = $signed({3'b000, top_q} + {3'b000, height_q});
  assign in_rect = (gx > lo_x) && (gx < hi_x) && (gy > lo_y) && (gy < hi_y);
  assign now32   = {1'b0, s1_now_q};

  always_comb begin
    logic [31:0] limit;
    fire_d      = 2'd0;
    redraw_d    = 1'b0;
    phase_d     = phase_q;
    dwell_dl_d  = dwell_dl_q;
    cur_delay_d = cur_delay_q;
    flash_d     = flash_q;
    double_d    = double_q;
    rearm_d     = rearm_q;
    repeat_dl_d = repeat_dl_q;
    limit       = 32'd0;
    now_plus    = now32 + {16'd0, cur_delay_q};

    if (flash_q >= 0) begin
      flash_d = flash_q - 4'sd1;
      fire_d  = 2'd1;
    end
    if (mode_q == MODE_DOUBLE) begin
      if (double_q >= 0) double_d = double_q - 5'sd1;
      if (double_d == 5'sd0) flash_d = FLASH_LOAD;
    end
    if (flash_d == 4'sd0) redraw_d = 1'b1;

    if (toggle_q) begin
      if (in_rect) begin
        if (rearm_q == 4'd0) begin
          unique case (phase_q)
            PH_IDLE, PH_ACTIVE: begin
              phase_d    = phase_q + 2'd1;
              redraw_d   = 1'b1;
              dwell_dl_d = now_plus;
            end
            default: begin
              if ($signed(now32) > $signed(dwell_dl_q)) begin
                phase_d  = phase_q + 2'd1;
                redraw_d = 1'b1;
                rearm_d  = REARM_LOAD;
              end
            end
          endcase
        end
      end else begin
        if (phase_q == PH_DWELL || phase_q == PH_RELEASE) begin
          dwell_dl_d = dwell_dl_q + {16'd0, decay_q};
          if ($signed(dwell_dl_d) > $signed(now_plus)) begin
            phase_d  = phase_q - 2'd1;
            redraw_d = 1'b1;
          end
        end
        if (rearm_q != 4'd0) rearm_d = rearm_q - 4'd1;
      end
      if (phase_d[1] && (($signed(now32) > $signed(repeat_dl_q)) || mode_q == MODE_HOLD))
      begin
        repeat_dl_d = now_plus;
        fire_d      = fire_d + 2'd1;
        flash_d     = FLASH_LOAD;
      end
    end else begin
      if (phase_q == PH_ACTIVE && mode_q != MODE_HOLD) begin
        phase_d = PH_IDLE;
        if (mode_q == MODE_ACCEL && cur_delay_q > DELAY_FLOOR)
          cur_delay_d = cur_delay_q - DELAY_STEP;
      end
      limit = now32 + {16'd0, cur_delay_d};
      if (in_rect) begin
        if (phase_d == PH_IDLE) begin
          phase_d    = PH_DWELL;
          redraw_d   = 1'b1;
          dwell_dl_d = limit;
        end else if (phase_d == PH_DWELL) begin
          if ($signed(now32) > $signed(dwell_dl_q)) begin
            phase_d  = PH_ACTIVE;
            redraw_d = 1'b1;
          end
        end
      end else if (phase_d == PH_DWELL || phase_d == PH_ACTIVE) begin
        dwell_dl_d = dwell_dl_q + {16'd0, decay_q};
        if ($signed(dwell_dl_d) > $signed(limit)) begin
          if (phase_d == PH_DWELL) begin
            if (mode_q == MODE_ACCEL) cur_delay_d = delay_q;
            redraw_d = 1'b1;
          end
          phase_d = PH_IDLE;
        end
      end
      if (phase_d == PH_ACTIVE) begin
        flash_d = FLASH_LOAD;
        if (mode_q == MODE_DOUBLE) double_d = DOUBLE_LOAD;
      end
    end
    flashing_d = (flash_d > 4'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= 12'd0;
      top_q       <= 12'd0;
      width_q     <= RST_RECT_SIZE;
      height_q    <= RST_RECT_SIZE;
      delay_q     <= RST_DELAY;
      mode_q      <= MODE_TAP;
      toggle_q    <= 1'b0;
      decay_q     <= 16'd0;
      phase_q     <= PH_IDLE;
      dwell_dl_q  <= 32'd0;
      cur_delay_q <= RST_DELAY;
      flash_q     <= FLASH_OFF;
      double_q    <= DOUBLE_OFF;
      rearm_q     <= 4'd0;
      repeat_dl_q <= 32'd0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      if (s1_adv) begin
        phase_q     <= phase_d;
        dwell_dl_q  <= dwell_dl_d;
        flash_q     <= flash_d;
        double_q    <= double_d;
        rearm_q     <= rearm_d;
        repeat_dl_q <= repeat_dl_d;
      end

      // a dwell delay write also reloads the working delay
      if (cfg_we_i && cfg_index_i == CFG_DWELL_DELAY) cur_delay_q <= cfg_wdata_i;
      else if (s1_adv) cur_delay_q <= cur_delay_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_RECT_LEFT:   left_q   <= cfg_wdata_i[11:0];
          CFG_RECT_TOP:    top_q    <= cfg_wdata_i[11:0];
          CFG_RECT_WIDTH:  width_q  <= cfg_wdata_i[11:0];
          CFG_RECT_HEIGHT: height_q <= cfg_wdata_i[11:0];
          CFG_DWELL_DELAY: delay_q  <= cfg_wdata_i;
          CFG_BUTTON_MODE: mode_q   <= mode_e'(cfg_wdata_i[1:0]);
          CFG_TOGGLE_EN:   toggle_q <= cfg_wdata_i[0];
          CFG_AWAY_DECAY:  decay_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_x_q   <= gaze_x_i;
      s1_y_q   <= gaze_y_i;
      s1_now_q <= now_time_i;
    end
    if (s1_adv) begin
      fire_q      <= fire_d;
      redraw_q    <= redraw_d;
      phase_out_q <= phase_d;
      flashing_q  <= flashing_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fire_count_o = fire_q;
  assign redraw_o     = redraw_q;
  assign phase_o      = phase_out_q;
  assign flashing_o   = flashing_q;

  `GDBQ_ASSERT_NXT(a_adv_gives_result, clk_i, rst_ni, s1_adv, out_valid_q)
  `GDBQ_ASSERT_NOW(a_stall_needs_sample, clk_i, rst_ni, in_stall_o, s1_valid_q)
  `GDBQ_ASSERT_NOW(a_flash_range, clk_i, rst_ni, 1'b1,
                   (flash_q >= FLASH_OFF) && (flash_q <= FLASH_LOAD))
  `GDBQ_ASSERT_NOW(a_counters_range, clk_i, rst_ni, 1'b1,
                   (rearm_q <= REARM_LOAD) && (double_q >= DOUBLE_OFF) &&
                   (double_q <= DOUBLE_LOAD))

endmodule

@@ bench/testbench.sv @@
// self-checking bench for gaze_dwell_button_qualifier_top
// depends on rtl/gdbq_pkg.sv and the top level; frame predictor lives in a scoreboard class
// stimulus: directed edge frames, then dwell episodes with noise over many register settings
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gdbq_pkg::*;

  localparam logic signed [3:0] FLASH_FRAMES  = 4'sd5;
  localparam logic signed [4:0] DOUBLE_FRAMES = 5'sd12;
  localparam logic [3:0]        REARM_FRAMES  = 4'd10;
  localparam logic [15:0]       ACCEL_STEP    = 16'd10;
  localparam logic [15:0]       ACCEL_FLOOR   = 16'd10;
  localparam int                N_SETTINGS    = 13;
  localparam int                FRAMES_PER_SETTING = 45;

  typedef struct packed {
    logic [1:0] fire_count;
    logic       redraw;
    phase_t     phase;
    logic       flashing;
  } frame_result_t;

  class dwell_scoreboard;
    logic [11:0] rect_left, rect_top, rect_width, rect_height;
    logic [15:0] dwell_delay, away_decay;
    mode_e       mode;
    logic        toggle_en;

    phase_t             phase;
    logic [31:0]        deadline, repeat_dl;
    logic [15:0]        cur_delay;
    logic signed [3:0]  flash_cnt;
    logic signed [4:0]  double_cnt;
    logic [3:0]         rearm_cnt;

    frame_result_t expected_frames[$];
    int errors;
    int checked;

    function new();
      rect_left = '0; rect_top = '0; rect_width = 12'd100; rect_height = 12'd100;
      dwell_delay = 16'd500; away_decay = '0; mode = MODE_TAP; toggle_en = 1'b0;
      phase = PH_IDLE; deadline = '0; repeat_dl = '0; cur_delay = 16'd500;
      flash_cnt = -4'sd1; double_cnt = -5'sd1; rearm_cnt = '0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] d);
      case (idx)
        CFG_RECT_LEFT:   rect_left = d[11:0];
        CFG_RECT_TOP:    rect_top = d[11:0];
        CFG_RECT_WIDTH:  rect_width = d[11:0];
        CFG_RECT_HEIGHT: rect_height = d[11:0];
        CFG_DWELL_DELAY: begin
          dwell_delay = d;
          cur_delay = d;
        end
        CFG_BUTTON_MODE: mode = mode_e'(d[1:0]);
        CFG_TOGGLE_EN:   toggle_en = d[0];
        CFG_AWAY_DECAY:  away_decay = d;
        default: ;
      endcase
    endfunction

    // signed 32-bit compare so deadlines survive wrap
    function bit later(logic [31:0] a, logic [31:0] b);
      return $signed(a) > $signed(b);
    endfunction

    function frame_result_t qualify_frame(logic signed [13:0] gx, logic signed [13:0] gy,
                                          logic [30:0] t);
      logic [31:0]   now, lim;
      logic [1:0]    fires;
      logic          draw, hit;
      int            x, y;
      frame_result_t r;
      now = {1'b0, t};
      x = gx;
      y = gy;
      fires = 2'd0;
      draw = 1'b0;

      if (flash_cnt >= 0) begin
        flash_cnt = flash_cnt - 4'sd1;
        fires = fires + 2'd1;
      end
      if (mode == MODE_DOUBLE) begin
        if (double_cnt >= 0) double_cnt = double_cnt - 5'sd1;
        if (double_cnt == 0) flash_cnt = FLASH_FRAMES;
      end
      if (flash_cnt == 0) draw = 1'b1;

      hit = x > int'(rect_left) && x < int'(rect_left) + int'(rect_width) &&
            y > int'(rect_top) && y < int'(rect_top) + int'(rect_height);

      if (toggle_en) begin
        if (hit) begin
          if (rearm_cnt == 0) begin
            case (phase)
              PH_IDLE, PH_ACTIVE: begin
                phase = phase + 2'd1;
                draw = 1'b1;
                deadline = now + cur_delay;
              end
              default: begin
                if (later(now, deadline)) begin
                  phase = phase + 2'd1;
                  draw = 1'b1;
                  rearm_cnt = REARM_FRAMES;
                end
              end
            endcase
          end
        end else begin
          if (phase == PH_DWELL || phase == PH_RELEASE) begin
            deadline = deadline + away_decay;
            lim = now + cur_delay;
            if (later(deadline, lim)) begin
              phase = phase - 2'd1;
              draw = 1'b1;
            end
          end
          if (rearm_cnt > 0) rearm_cnt = rearm_cnt - 4'd1;
        end
        if (phase > PH_DWELL && (later(now, repeat_dl) || mode == MODE_HOLD)) begin
          repeat_dl = now + cur_delay;
          fires = fires + 2'd1;
          flash_cnt = FLASH_FRAMES;
        end
      end else begin
        if (phase == PH_ACTIVE && mode != MODE_HOLD) begin
          phase = PH_IDLE;
          if (mode == MODE_ACCEL && cur_delay > ACCEL_FLOOR) cur_delay = cur_delay - ACCEL_STEP;
        end
        if (hit) begin
          if (phase == PH_IDLE) begin
            phase = PH_DWELL;
            draw = 1'b1;
            deadline = now + cur_delay;
          end else if (phase == PH_DWELL) begin
            if (later(now, deadline)) begin
              phase = PH_ACTIVE;
              draw = 1'b1;
            end
          end
        end else if (phase == PH_DWELL || phase == PH_ACTIVE) begin
          deadline = deadline + away_decay;
          lim = now + cur_delay;
          if (later(deadline, lim)) begin
            // abandoning a dwell in accel mode restores the configured delay
            if (phase == PH_DWELL) begin
              if (mode == MODE_ACCEL) cur_delay = dwell_delay;
              draw = 1'b1;
            end
            phase = PH_IDLE;
          end
        end
        if (phase == PH_ACTIVE) begin
          flash_cnt = FLASH_FRAMES;
          if (mode == MODE_DOUBLE) double_cnt = DOUBLE_FRAMES;
        end
      end

      r.fire_count = fires;
      r.redraw = draw;
      r.phase = phase;
      r.flashing = flash_cnt > 0;
      return r;
    endfunction

    function void note_sample(logic signed [13:0] gx, logic signed [13:0] gy, logic [30:0] t);
      expected_frames.insert(expected_frames.size(), qualify_frame(gx, gy, t));
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("error: unexpected result: fire %0d redraw %0d phase %0d flash %0d",
                   got.fire_count, got.redraw, got.phase, got.flashing);
        return;
      end
      want = expected_frames.pop_front();
      checked++;
      if (want.fire_count != got.fire_count || want.redraw != got.redraw ||
          want.phase != got.phase || want.flashing != got.flashing) begin
        errors++;
        if (errors <= 10) begin
          $display("error: frame %0d expected fire %0d redraw %0d phase %0d flash %0d",
                   checked, want.fire_count, want.redraw, want.phase, want.flashing);
          $display("       got fire %0d redraw %0d phase %0d flash %0d",
                   got.fire_count, got.redraw, got.phase, got.flashing);
        end
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  cfg_idx_e           cfg_index_i;
  logic [15:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [13:0] gaze_x_i;
  logic signed [13:0] gaze_y_i;
  logic [30:0]        now_time_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         fire_count_o;
  logic               redraw_o;
  logic [1:0]         phase_o;
  logic               flashing_o;

  dwell_scoreboard sb = new();

  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          n_settings;
  logic [30:0] now_t;

  gaze_dwell_button_qualifier_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .gaze_x_i     (gaze_x_i),
    .gaze_y_i     (gaze_y_i),
    .now_time_i   (now_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fire_count_o (fire_count_o),
    .redraw_o     (redraw_o),
    .phase_o      (phase_o),
    .flashing_o   (flashing_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // everything is sampled before the edge updates the block
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) sb.note_sample(gaze_x_i, gaze_y_i, now_time_i);
      if (out_valid_o && !out_stall_i)
        sb.check_frame('{fire_count_o, redraw_o, phase_o, flashing_o});
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_sample(input logic signed [13:0] gx, input logic signed [13:0] gy,
                             input logic [30:0] t);
    if (items_sent < 225) begin
      send_idle_pct = 20;
      recv_stall_pct = 49;
    end else if (items_sent < 450) begin
      send_idle_pct = 49;
      recv_stall_pct = 20;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    gaze_x_i <= gx;
    gaze_y_i <= gy;
    now_time_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain(input int extra);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  function automatic int pick_coord(int lo, int span);
    if (span >= 2 && $urandom_range(0, 9) != 0) return lo + int'($urandom_range(1, span - 1));
    // strictness of the edges
    return $urandom_range(0, 1) ? lo : lo + span;
  endfunction

  task automatic apply_settings(input int p);
    logic [15:0] left, top, wid, hgt, dly, dcy;
    logic        tog;
    left = {4'($urandom), 12'($urandom_range(0, 4095))};
    top  = {4'($urandom), 12'($urandom_range(0, 4095))};
    wid  = {4'($urandom),
            12'($urandom_range(0, 1) ? $urandom_range(2, 200) : $urandom_range(1, 4095))};
    hgt  = {4'($urandom),
            12'($urandom_range(0, 1) ? $urandom_range(2, 200) : $urandom_range(1, 4095))};
    dly  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 300)) : 16'($urandom);
    case ($urandom_range(0, 4))
      0:       dcy = 16'd0;
      1:       dcy = 16'($urandom);
      default: dcy = 16'($urandom_range(0, 40));
    endcase
    tog = (p >= 4 && p < 8) || p == 9 || (p > 9 && $urandom_range(0, 1));
    case (p)
      0: begin
        left = 16'd0; top = 16'd0; wid = 16'd4095; hgt = 16'd4095;
        dly = 16'd0; dcy = 16'hffff;
      end
      1: begin
        left = 16'd4095; top = 16'd4095; wid = 16'd4095; hgt = 16'd4095;
        dly = 16'hffff; dcy = 16'd0;
      end
      2: begin
        wid = 16'd2; hgt = 16'd2;
      end
      3: wid = 16'd1;
      default: ;
    endcase
    write_register(CFG_RECT_LEFT, left);
    write_register(CFG_RECT_TOP, top);
    write_register(CFG_RECT_WIDTH, wid);
    write_register(CFG_RECT_HEIGHT, hgt);
    write_register(CFG_DWELL_DELAY, dly);
    write_register(CFG_BUTTON_MODE, {14'($urandom), 2'(p % 4)});
    write_register(CFG_TOGGLE_EN, {15'($urandom), tog});
    write_register(CFG_AWAY_DECAY, dcy);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic send_frame(input bit aim);
    int x, y, r;
    r = $urandom_range(0, 99);
    if (r < 2) now_t = 31'($urandom);
    else if (r < 4) now_t = 31'h7fffffff - 31'($urandom_range(0, 300));
    else now_t = now_t + 31'($urandom_range(0, sb.dwell_delay / 4 + 4));
    if (aim) begin
      x = pick_coord(sb.rect_left, sb.rect_width);
      y = pick_coord(sb.rect_top, sb.rect_height);
    end else begin
      x = int'($urandom_range(0, 12287)) - 4096;
      y = int'($urandom_range(0, 12287)) - 4096;
    end
    send_sample(14'(x), 14'(y), now_t);
  endtask

  task automatic run_setting(input int p);
    int  count, k, j;
    bit  paused;
    count = 0;
    paused = 0;
    while (count < FRAMES_PER_SETTING) begin
      // hold the sender off until the pipeline is empty
      if (p % 4 == 1 && count >= FRAMES_PER_SETTING / 2 && !paused) begin
        drain(0);
        paused = 1;
      end
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(1, 12);
        repeat (k) send_frame(1);
        j = $urandom_range(0, 6);
        repeat (j) send_frame(0);
        count += k + j;
      end else begin
        j = $urandom_range(1, 5);
        repeat (j) send_frame(0);
        count += j;
      end
    end
  endtask

  // leave the latch in phase 3 so the next setting sees it with toggle cleared
  task automatic steer_to_release();
    int n;
    n = 0;
    while (sb.phase != PH_RELEASE && n < 60) begin
      now_t = now_t + 31'(sb.cur_delay) + 31'd1;
      if (sb.rearm_cnt > 0)
        send_sample(-14'sd4096, -14'sd4096, now_t);
      else
        send_sample(14'(int'(sb.rect_left) + 1), 14'(int'(sb.rect_top) + 1), now_t);
      n++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_RECT_LEFT;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    gaze_x_i = '0;
    gaze_y_i = '0;
    now_time_i = '0;
    send_idle_pct = 20;
    recv_stall_pct = 49;
    items_sent = 0;
    n_settings = 0;
    now_t = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings: rectangle 0..100, delay 500, tap
    send_sample(-14'sd4096, -14'sd4096, 31'd0);
    send_sample(14'sd8191, 14'sd8191, 31'd1);
    send_sample(14'sd0, 14'sd50, 31'd2);
    send_sample(14'sd50, 14'sd0, 31'd3);
    send_sample(14'sd100, 14'sd50, 31'd4);
    send_sample(14'sd50, 14'sd100, 31'd5);
    send_sample(14'sd99, 14'sd99, 31'd6);
    send_sample(14'sd1, 14'sd1, 31'd300);
    send_sample(14'sd50, 14'sd50, 31'd507);
    send_sample(14'sd50, 14'sd50, 31'd508);
    send_sample(-14'sd1, 14'sd50, 31'd600);
    send_sample(14'sd50, 14'sd50, 31'd1009);
    send_sample(14'sd8191, -14'sd4096, 31'd2147483600);
    // deadline lands past the signed wrap
    send_sample(14'sd50, 14'sd50, 31'd2147483600);
    send_sample(14'sd50, 14'sd50, 31'd2147483647);
    send_sample(14'sd50, 14'sd50, 31'd0);
    send_sample(14'sd50, 14'sd50, 31'd1000);
    send_sample(-14'sd4096, 14'sd8191, 31'd1001);

    for (int p = 0; p < N_SETTINGS; p++) begin
      drain(4);
      apply_settings(p);
      run_setting(p);
      if (p == 7) steer_to_release();
    end

    drain(8);
    $display("run covered %0d frames over %0d register settings", sb.checked, n_settings);
    $display("all four modes with and without toggle, rectangle and delay extremes, time wrap");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS gaze_dwell_button_qualifier_top");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("FAIL gaze_dwell_button_qualifier_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("FAIL gaze_dwell_button_qualifier_top");
    $finish;
  end

endmodule
